### design/mrd_pkg.sv
package mrd_pkg;

   // Result status codes, in checking order
   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_SHORT       = 3'd1,
      STATUS_EXCEPTION   = 3'd2,
      STATUS_WRONG_FUNC  = 3'd3,
      STATUS_INCOMPLETE  = 3'd4,
      STATUS_CRC_ERROR   = 3'd5,
      STATUS_FEW_DATA    = 3'd6
   } status_type;

   // Value type register codes
   localparam logic [1:0] VTYPE_U16 = 2'd0;
   localparam logic [1:0] VTYPE_S16 = 2'd1;
   localparam logic [1:0] VTYPE_U32 = 2'd2;
   localparam logic [1:0] VTYPE_F32 = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_EXPECTED_FUNCTION = 2'd0;
   localparam logic [1:0] CSR_VALUE_TYPE        = 2'd1;
   localparam logic [1:0] CSR_LITTLE_ENDIAN     = 2'd2;
   localparam logic [1:0] CSR_SWAP_WORDS        = 2'd3;

   // Frame layout and CRC constants
   localparam logic [15:0] CRC_SEED        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [7:0]  EXCEPTION_FLAG  = 8'h80;
   localparam int          MIN_FRAME_BYTES = 5;
   localparam int          HEADER_BYTES    = 3;
   localparam logic [7:0]  RESET_FUNCTION  = 8'd3;

   // Configuration registers
   typedef struct packed {
      logic [7:0] expected_function;
      logic [1:0] value_type;
      logic       little_endian_bytes;
      logic       swap_words;
   } config_type;

   // Frame summary after the current byte is folded in
   typedef struct packed {
      logic [7:0]  function_byte;
      logic [7:0]  count_byte;
      logic [31:0] data_head;
      logic [15:0] running_crc;
      logic [15:0] received_crc;
      logic        short_frame;
      logic        incomplete;
   } frame_info_type;

   // One byte of reflected CRC-16, unrolled over the eight bits
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] swap16(input logic [15:0] w);
      return {w[7:0], w[15:8]};
   endfunction

endpackage

### design/mrd_req_if.sv
interface mrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

### design/mrd_rsp_if.sv
interface mrd_rsp_if;
   logic                valid;
   logic                ready;
   mrd_pkg::status_type status;
   logic [31:0]         value_bits;
   logic [7:0]          detail_byte;

   modport source (output valid, output status, output value_bits, output detail_byte,
                   input ready);
   modport sink (input valid, input status, input value_bits, input detail_byte,
                 output ready);
endinterface

### design/modbus_rtu_response_decoder.sv
// Modbus RTU read-response decoder. Frame bytes enter one per transaction
// on req, with frame_end set on the last byte; the block sustains one byte
// per clock unless an end byte is held back by an untaken result. A byte
// sits in an input register, then the CRC-16 update, field capture and, on
// the end byte, all frame checks happen in one pass into the result
// register, so a frame's result reaches rsp from the result register once
// its end byte moves on from the input register. Bytes wait on rsp
// only behind an end byte: an end byte holds the input register while the
// previous result is still untaken, and req stays stalled until it moves.
// Configuration writes on csr_ are meant for idle periods between frames.
module modbus_rtu_response_decoder #(
   parameter int POSITION_BITS = 9
) (
   input  logic       clock,
   input  logic       reset,
   mrd_req_if.sink    req,
   mrd_rsp_if.source  rsp,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   mrd_pkg::config_type     cfg_ff;
   mrd_pkg::frame_info_type info;
   mrd_pkg::status_type     status_in;
   mrd_pkg::status_type     status_ff;
   logic [31:0]             value_in, value_ff;
   logic [7:0]              detail_in, detail_ff;
   logic                    in_valid_ff;
   logic [7:0]              in_byte_ff;
   logic                    in_end_ff;
   logic                    rsp_valid_ff;
   logic                    advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_function   <= mrd_pkg::RESET_FUNCTION;
         cfg_ff.value_type          <= mrd_pkg::VTYPE_U16;
         cfg_ff.little_endian_bytes <= 1'b0;
         cfg_ff.swap_words          <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mrd_pkg::CSR_EXPECTED_FUNCTION: cfg_ff.expected_function <= csr_write_data;
            mrd_pkg::CSR_VALUE_TYPE:        cfg_ff.value_type <= csr_write_data[1:0];
            mrd_pkg::CSR_LITTLE_ENDIAN:     cfg_ff.little_endian_bytes <= csr_write_data[0];
            mrd_pkg::CSR_SWAP_WORDS:        cfg_ff.swap_words <= csr_write_data[0];
         endcase
      end
   end

   // Stage advances unless an end byte would overwrite an untaken result
   assign advance   = in_valid_ff && (!in_end_ff || !rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.frame_byte;
         in_end_ff  <= req.frame_end;
      end
   end

   mrd_frame_state #(
      .POSITION_BITS (POSITION_BITS)
   ) u_frame_state (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .frame_byte (in_byte_ff),
      .frame_end  (in_end_ff),
      .info       (info)
   );

   mrd_frame_check u_frame_check (
      .info        (info),
      .cfg         (cfg_ff),
      .status      (status_in),
      .value_bits  (value_in),
      .detail_byte (detail_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_end_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_end_ff) begin
         status_ff <= status_in;
         value_ff  <= value_in;
         detail_ff <= detail_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.value_bits  = value_ff;
   assign rsp.detail_byte = detail_ff;

endmodule

### design/mrd_frame_state.sv
module mrd_frame_state #(
   parameter int POSITION_BITS = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [7:0]              frame_byte,
   input  logic                    frame_end,
   output mrd_pkg::frame_info_type info
);

   localparam int LB = POSITION_BITS + 1;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [15:0]              crc_ff, crc_in;
   logic [7:0]               function_ff, function_in;
   logic [7:0]               count_ff, count_in;
   logic [31:0]              head_ff, head_in;
   logic [15:0]              rx_crc_ff, rx_crc_in;
   logic [POSITION_BITS-1:0] crc_end;
   logic [LB-1:0]            length;

   // Header and data capture by position
   always_comb begin
      function_in = function_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      if (pos_ff == POSITION_BITS'(1)) begin
         function_in = frame_byte;
      end else if (pos_ff == POSITION_BITS'(2)) begin
         count_in = frame_byte;
      end
      if (pos_ff == POSITION_BITS'(3)) begin
         head_in[31:24] = frame_byte;
      end else if (pos_ff == POSITION_BITS'(4)) begin
         head_in[23:16] = frame_byte;
      end else if (pos_ff == POSITION_BITS'(5)) begin
         head_in[15:8] = frame_byte;
      end else if (pos_ff == POSITION_BITS'(6)) begin
         head_in[7:0] = frame_byte;
      end
   end

   // CRC over header and data, then capture of the trailing CRC bytes
   always_comb begin
      crc_end   = POSITION_BITS'(count_in) + POSITION_BITS'(mrd_pkg::HEADER_BYTES);
      crc_in    = crc_ff;
      rx_crc_in = rx_crc_ff;
      priority if (pos_ff < crc_end) begin
         crc_in = mrd_pkg::crc_byte(crc_ff, frame_byte);
      end else if (pos_ff == crc_end) begin
         rx_crc_in[7:0] = frame_byte;
      end else if (pos_ff == crc_end + POSITION_BITS'(1)) begin
         rx_crc_in[15:8] = frame_byte;
      end else begin
         // bytes after the received CRC are ignored
         crc_in = crc_ff;
      end
   end

   // Saturating position count
   assign pos_in = (&pos_ff) ? pos_ff : pos_ff + POSITION_BITS'(1);
   assign length = {1'b0, pos_ff} + LB'(1);

   always_comb begin
      info.function_byte = function_in;
      info.count_byte    = count_in;
      info.data_head     = head_in;
      info.running_crc   = crc_in;
      info.received_crc  = rx_crc_in;
      info.short_frame   = length < LB'(mrd_pkg::MIN_FRAME_BYTES);
      info.incomplete    = length < (LB'(count_in) + LB'(mrd_pkg::MIN_FRAME_BYTES));
   end

   // Frame state returns to reset after the end byte
   always_ff @(posedge clock) begin
      if (reset || (advance && frame_end)) begin
         pos_ff      <= '0;
         crc_ff      <= mrd_pkg::CRC_SEED;
         function_ff <= '0;
         count_ff    <= '0;
         head_ff     <= '0;
         rx_crc_ff   <= '0;
      end else if (advance) begin
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         function_ff <= function_in;
         count_ff    <= count_in;
         head_ff     <= head_in;
         rx_crc_ff   <= rx_crc_in;
      end
   end

endmodule

### design/mrd_frame_check.sv
module mrd_frame_check (
   input  mrd_pkg::frame_info_type info,
   input  mrd_pkg::config_type     cfg,
   output mrd_pkg::status_type     status,
   output logic [31:0]             value_bits,
   output logic [7:0]              detail_byte
);

   logic        is_16bit;
   logic [15:0] hi_word, lo_word, hi_sel, lo_sel, w16;

   // Byte and word reordering
   always_comb begin
      hi_word  = info.data_head[31:16];
      lo_word  = info.data_head[15:0];
      is_16bit = (cfg.value_type == mrd_pkg::VTYPE_U16) ||
                 (cfg.value_type == mrd_pkg::VTYPE_S16);
      w16      = cfg.little_endian_bytes ? mrd_pkg::swap16(hi_word) : hi_word;
      hi_sel   = cfg.swap_words ? lo_word : hi_word;
      lo_sel   = cfg.swap_words ? hi_word : lo_word;
      if (cfg.little_endian_bytes) begin
         hi_sel = mrd_pkg::swap16(hi_sel);
         lo_sel = mrd_pkg::swap16(lo_sel);
      end
   end

   // Checks in priority order
   always_comb begin
      status      = mrd_pkg::STATUS_OK;
      value_bits  = '0;
      detail_byte = '0;
      priority if (info.short_frame) begin
         status = mrd_pkg::STATUS_SHORT;
      end else if ((info.function_byte & mrd_pkg::EXCEPTION_FLAG) != 8'd0) begin
         status      = mrd_pkg::STATUS_EXCEPTION;
         detail_byte = info.count_byte;
      end else if (info.function_byte != cfg.expected_function) begin
         status      = mrd_pkg::STATUS_WRONG_FUNC;
         detail_byte = info.function_byte;
      end else if (info.incomplete) begin
         status = mrd_pkg::STATUS_INCOMPLETE;
      end else if (info.running_crc != info.received_crc) begin
         status = mrd_pkg::STATUS_CRC_ERROR;
      end else if (is_16bit) begin
         if (info.count_byte < 8'd2) begin
            status      = mrd_pkg::STATUS_FEW_DATA;
            detail_byte = info.count_byte;
         end else if (cfg.value_type == mrd_pkg::VTYPE_S16) begin
            value_bits = {{16{w16[15]}}, w16};
         end else begin
            value_bits = {16'h0000, w16};
         end
      end else begin
         if (info.count_byte < 8'd4) begin
            status      = mrd_pkg::STATUS_FEW_DATA;
            detail_byte = info.count_byte;
         end else begin
            value_bits = {hi_sel, lo_sel};
         end
      end
   end

endmodule
